@@ hdl/rgpbt_pkg.sv @@
// ----------------------------------------------------------------------------
// rgpbt_pkg
// Types and constants shared by the ray ground-plane bounds test pipeline.
// ----------------------------------------------------------------------------
package rgpbt_pkg;

  localparam int RAY_W = 16;
  localparam int ROT_W = 16;
  localparam int PROD_W = RAY_W + ROT_W;
  localparam int U_W = PROD_W + 2;
  localparam int REG_W = 48;
  localparam int LIM_W = 15;
  localparam int IDX_W = 3;

  typedef logic signed [RAY_W-1:0] ray_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_X    = 3'd0,
    REG_ROT_Y    = 3'd1,
    REG_ROT_Z    = 3'd2,
    REG_CAM_POS  = 3'd3,
    REG_MARGIN   = 3'd4,
    REG_HALF_LEN = 3'd5,
    REG_HALF_WID = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CAUSE_ON_CARPET = 2'd0,
    CAUSE_HORIZON   = 2'd1,
    CAUSE_BEYOND    = 2'd2
  } cause_t;

  typedef struct packed {
    logic [REG_W-1:0] rot_x;
    logic [REG_W-1:0] rot_y;
    logic [REG_W-1:0] rot_z;
    logic [REG_W-1:0] cam_pos;
    logic [LIM_W-1:0] margin;
    logic [LIM_W-1:0] half_len;
    logic [LIM_W-1:0] half_wid;
  } cfg_t;

  typedef struct packed {
    logic signed [U_W-1:0] x;
    logic signed [U_W-1:0] y;
    logic signed [U_W-1:0] z;
  } vec_t;

  localparam logic [REG_W-1:0] ROT_X_RST = {16'h0000, 16'h0000, 16'h4000};
  localparam logic [REG_W-1:0] ROT_Y_RST = {16'h0000, 16'h4000, 16'h0000};
  localparam logic [REG_W-1:0] ROT_Z_RST = {16'h4000, 16'h0000, 16'h0000};
  localparam logic [LIM_W-1:0] HALF_LEN_RST = 15'd5700;
  localparam logic [LIM_W-1:0] HALF_WID_RST = 15'd3700;

endpackage

@@ hdl/rgpbt_rotate.sv @@
// ----------------------------------------------------------------------------
// rgpbt_rotate
// Two-stage rotation of the camera-frame ray into the field frame:
// nine products registered, then the three row sums registered.
// ----------------------------------------------------------------------------
module rgpbt_rotate (
  input  logic              clk,
  input  logic              rst_n,
  input  rgpbt_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgpbt_pkg::ray_t   in_x,
  input  rgpbt_pkg::ray_t   in_y,
  input  rgpbt_pkg::ray_t   in_z,
  output logic              out_valid,
  input  logic              out_ready,
  output rgpbt_pkg::vec_t   out_vec
);
  import rgpbt_pkg::*;

  logic  v1_r, v2_r;
  logic  adv1, adv2;
  prod_t prod_nxt [9];
  prod_t prod_r   [9];
  vec_t  vec_nxt;
  vec_t  vec_r;
  ray_t  ray [3];
  logic [REG_W-1:0] rows [3];

  assign ray[0]  = in_x;
  assign ray[1]  = in_y;
  assign ray[2]  = in_z;
  assign rows[0] = cfg.rot_x;
  assign rows[1] = cfg.rot_y;
  assign rows[2] = cfg.rot_z;

  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[3*r+k] = PROD_W'($signed(rows[r][ROT_W*k +: ROT_W])) * PROD_W'(ray[k]);
      end
    end
  end

  always_comb begin
    vec_nxt.x = U_W'(prod_r[0]) + U_W'(prod_r[1]) + U_W'(prod_r[2]);
    vec_nxt.y = U_W'(prod_r[3]) + U_W'(prod_r[4]) + U_W'(prod_r[5]);
    vec_nxt.z = U_W'(prod_r[6]) + U_W'(prod_r[7]) + U_W'(prod_r[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) prod_r <= prod_nxt;
    if (adv2 && v1_r) vec_r <= vec_nxt;
  end

  assign out_valid = v2_r;
  assign out_vec   = vec_r;

endmodule

@@ hdl/rgpbt_bounds.sv @@
// ----------------------------------------------------------------------------
// rgpbt_bounds
// Two-stage ground-plane test: horizon check and cross products registered,
// then the carpet extent compares and the cause registered.
// ----------------------------------------------------------------------------
module rgpbt_bounds #(
  parameter int FRAC_BITS = 14,
  parameter int POS_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rgpbt_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgpbt_pkg::vec_t   in_vec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_of_field,
  output rgpbt_pkg::cause_t cause
);
  import rgpbt_pkg::*;

  localparam int MW    = LIM_W + FRAC_BITS;
  localparam int CW    = ((MW > U_W) ? MW : U_W) + 2;
  localparam int EXT_W = (3 * POS_WIDTH > REG_W) ? 3 * POS_WIDTH : REG_W;
  localparam int PW    = POS_WIDTH + U_W;
  localparam int CLW   = LIM_W + U_W + 2;
  localparam int SW    = ((PW > CLW) ? PW : CLW) + 1;

  logic v3_r, v4_r;
  logic adv3, adv4;

  logic [MW-1:0]          margin_sh;
  logic signed [CW-1:0]   hz_sum;
  logic [EXT_W-1:0]       cam_wide;
  logic signed [POS_WIDTH-1:0] px, py, pz;
  logic signed [U_W:0]    depth;

  logic                   hz_nxt, hz_r;
  logic signed [PW-1:0]   ax_nxt, bx_nxt, ay_nxt, by_nxt;
  logic signed [PW-1:0]   ax_r, bx_r, ay_r, by_r;
  logic signed [CLW-1:0]  cx_nxt, cy_nxt, cx_r, cy_r;

  logic signed [SW-1:0]   axe, bxe, aye, bye, cxe, cye;
  logic                   exceed;
  logic                   oof_nxt, oof_r;
  cause_t                 cause_nxt, cause_r;

  assign adv4     = !v4_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign in_ready = adv3;

  // horizon: uz + (margin << FRAC_BITS) >= 0
  assign margin_sh = {cfg.margin, {FRAC_BITS{1'b0}}};
  assign hz_sum    = CW'(in_vec.z) + $signed(CW'(margin_sh));
  assign hz_nxt    = !hz_sum[CW-1];

  assign cam_wide = EXT_W'(cfg.cam_pos);
  assign px       = $signed(cam_wide[0 +: POS_WIDTH]);
  assign py       = $signed(cam_wide[POS_WIDTH +: POS_WIDTH]);
  assign pz       = $signed(cam_wide[2*POS_WIDTH +: POS_WIDTH]);
  assign depth    = -((U_W+1)'(in_vec.z));

  assign ax_nxt = PW'(pz) * PW'(in_vec.x);
  assign bx_nxt = PW'(in_vec.z) * PW'(px);
  assign ay_nxt = PW'(pz) * PW'(in_vec.y);
  assign by_nxt = PW'(in_vec.z) * PW'(py);
  assign cx_nxt = CLW'($signed({1'b0, cfg.half_len})) * CLW'(depth);
  assign cy_nxt = CLW'($signed({1'b0, cfg.half_wid})) * CLW'(depth);

  assign axe = SW'(ax_r);
  assign bxe = SW'(bx_r);
  assign aye = SW'(ay_r);
  assign bye = SW'(by_r);
  assign cxe = SW'(cx_r);
  assign cye = SW'(cy_r);

  assign exceed = (axe > bxe + cxe) || (bxe > axe + cxe) ||
                  (aye > bye + cye) || (bye > aye + cye);

  always_comb begin
    if (hz_r) begin
      oof_nxt   = 1'b1;
      cause_nxt = CAUSE_HORIZON;
    end else if (exceed) begin
      oof_nxt   = 1'b1;
      cause_nxt = CAUSE_BEYOND;
    end else begin
      oof_nxt   = 1'b0;
      cause_nxt = CAUSE_ON_CARPET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) v3_r <= in_valid;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      hz_r <= hz_nxt;
      ax_r <= ax_nxt;
      bx_r <= bx_nxt;
      ay_r <= ay_nxt;
      by_r <= by_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
    if (adv4 && v3_r) begin
      oof_r   <= oof_nxt;
      cause_r <= cause_nxt;
    end
  end

  assign out_valid    = v4_r;
  assign out_of_field = oof_r;
  assign cause        = cause_r;

endmodule

@@ hdl/ray_ground_plane_bounds_test.sv @@
// ----------------------------------------------------------------------------
// ray_ground_plane_bounds_test
// out_valid comes from the last of four registered stages: two in rgpbt_rotate, two in rgpbt_bounds
// throughput: one transaction per cycle while out_ready does not stall the four-stage pipeline
// stalls hold every full stage in place while empty stages still fill; a stage refills as soon as it drains
// reset: synchronous, clears stage valid bits and loads register defaults
// ----------------------------------------------------------------------------
module ray_ground_plane_bounds_test #(
  parameter int FRAC_BITS = 14,
  parameter int POS_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rgpbt_pkg::IDX_W-1:0] cfg_index,
  input  logic [rgpbt_pkg::REG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rgpbt_pkg::ray_t             in_ray_cam_x,
  input  rgpbt_pkg::ray_t             in_ray_cam_y,
  input  rgpbt_pkg::ray_t             in_ray_cam_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_out_of_field,
  output logic [1:0]                  out_cause
);
  import rgpbt_pkg::*;

  cfg_t   cfg_r;
  vec_t   rot_vec;
  logic   rot_valid, rot_ready;
  cause_t cause_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_x    <= ROT_X_RST;
      cfg_r.rot_y    <= ROT_Y_RST;
      cfg_r.rot_z    <= ROT_Z_RST;
      cfg_r.cam_pos  <= '0;
      cfg_r.margin   <= '0;
      cfg_r.half_len <= HALF_LEN_RST;
      cfg_r.half_wid <= HALF_WID_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROT_X:    cfg_r.rot_x    <= cfg_data;
        REG_ROT_Y:    cfg_r.rot_y    <= cfg_data;
        REG_ROT_Z:    cfg_r.rot_z    <= cfg_data;
        REG_CAM_POS:  cfg_r.cam_pos  <= cfg_data;
        REG_MARGIN:   cfg_r.margin   <= cfg_data[LIM_W-1:0];
        REG_HALF_LEN: cfg_r.half_len <= cfg_data[LIM_W-1:0];
        REG_HALF_WID: cfg_r.half_wid <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  rgpbt_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_ray_cam_x),
    .in_y      (in_ray_cam_y),
    .in_z      (in_ray_cam_z),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_vec   (rot_vec)
  );

  rgpbt_bounds #(
    .FRAC_BITS (FRAC_BITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_bounds (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (rot_valid),
    .in_ready     (rot_ready),
    .in_vec       (rot_vec),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_of_field (out_out_of_field),
    .cause        (cause_w)
  );

  assign out_cause = cause_w;

  a_flag_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_of_field == (out_cause != CAUSE_ON_CARPET)))
    else $error("out_of_field disagrees with cause");

  a_empty_output_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !rot_valid)
    else $error("pipeline not empty after reset");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray ground-plane bounds test. A stimulus table
// of rays and register writes runs first. Random rays follow over several
// rotation, camera and carpet settings, including both extremes. Every result
// is compared with the table's own cause for typed rays, and otherwise with an
// exact integer classification of the ray kept in the bench. Both handshakes idle
// at random, and the receiver stalls long enough at times to back the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import rgpbt_pkg::*;

  localparam int FRAC = 14;
  localparam int POS_W = 16;
  localparam int LATENCY = 4;
  localparam int PHASES = 8;
  localparam int RAYS_PER_PHASE = 225;
  localparam int STEADY_FROM = 900;
  localparam int STEADY_TO = 1200;
  localparam int HOLD_AT_A = 500;
  localparam int HOLD_AT_B = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic   oof;
    cause_t cause;
  } verdict_t;

  typedef enum logic {STEP_RAY, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [IDX_W-1:0] idx;
    logic [REG_W-1:0] data;
    ray_t             x;
    ray_t             y;
    ray_t             z;
    bit               typed;
    cause_t           cause;
  } step_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  ray_t             in_ray_cam_x = '0;
  ray_t             in_ray_cam_y = '0;
  ray_t             in_ray_cam_z = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_out_of_field;
  logic [1:0]       out_cause;

  cfg_t     field_cfg;
  verdict_t expected_verdicts[$];
  step_t    plan[$];
  verdict_t want;
  int       errors = 0;
  int       rays_sent = 0;
  int       results_seen = 0;
  int       cfg_writes = 0;
  int       hold_left = 0;
  int       stall_cycles = 0;
  int       cause_tally[3] = '{0, 0, 0};

  ray_ground_plane_bounds_test #(
    .FRAC_BITS(FRAC),
    .POS_WIDTH(POS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ray_cam_x(in_ray_cam_x),
    .in_ray_cam_y(in_ray_cam_y),
    .in_ray_cam_z(in_ray_cam_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_out_of_field(out_out_of_field),
    .out_cause(out_cause)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint dot_row(logic [REG_W-1:0] row, ray_t a, ray_t b, ray_t c);
    return longint'($signed(row[15:0])) * longint'(a) +
           longint'($signed(row[31:16])) * longint'(b) +
           longint'($signed(row[47:32])) * longint'(c);
  endfunction

  function automatic bit off_carpet(longint a, longint b, longint lim);
    return (a > b + lim) || (b > a + lim);
  endfunction

  function automatic verdict_t classify_ray(ray_t rx, ray_t ry, ray_t rz);
    longint   ux, uy, uz, px, py, pz, depth, margin;
    verdict_t v;
    ux = dot_row(field_cfg.rot_x, rx, ry, rz);
    uy = dot_row(field_cfg.rot_y, rx, ry, rz);
    uz = dot_row(field_cfg.rot_z, rx, ry, rz);
    margin = longint'(field_cfg.margin) << FRAC;
    if (uz >= -margin) begin
      v.oof = 1'b1;
      v.cause = CAUSE_HORIZON;
    end else begin
      px = longint'($signed(field_cfg.cam_pos[0 +: POS_W]));
      py = longint'($signed(field_cfg.cam_pos[POS_W +: POS_W]));
      pz = longint'($signed(field_cfg.cam_pos[2*POS_W +: POS_W]));
      depth = -uz;
      if (off_carpet(pz * ux, uz * px, longint'(field_cfg.half_len) * depth) ||
          off_carpet(pz * uy, uz * py, longint'(field_cfg.half_wid) * depth)) begin
        v.oof = 1'b1;
        v.cause = CAUSE_BEYOND;
      end else begin
        v.oof = 1'b0;
        v.cause = CAUSE_ON_CARPET;
      end
    end
    return v;
  endfunction

  function automatic step_t ray_step(ray_t x, ray_t y, ray_t z, bit typed, cause_t cause);
    step_t s;
    s.kind = STEP_RAY;
    s.idx = '0;
    s.data = '0;
    s.x = x;
    s.y = y;
    s.z = z;
    s.typed = typed;
    s.cause = cause;
    return s;
  endfunction

  function automatic step_t write_step(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    step_t s;
    s = ray_step('0, '0, '0, 1'b0, CAUSE_ON_CARPET);
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic void add_step(step_t s);
    plan.insert(plan.size(), s);
  endfunction

  function automatic void expect_verdict(verdict_t v);
    expected_verdicts.insert(expected_verdicts.size(), v);
  endfunction

  function automatic ray_t pick_component();
    int r;
    r = $urandom_range(99);
    if (r < 60) return ray_t'(int'($urandom_range(32768)) - 16384);
    if (r < 80) return ray_t'($urandom);
    case ($urandom_range(6))
      0: return 16'sh8000;
      1: return -16'sh4000;
      2: return 16'sh0000;
      3: return 16'sh4000;
      4: return 16'sh7fff;
      5: return -16'sh0001;
      default: return 16'sh0001;
    endcase
  endfunction

  // mode 0 signed axis, mode 1 arbitrary bits, otherwise axis with noise
  function automatic logic [REG_W-1:0] make_row(int col, int mode);
    logic [REG_W-1:0] row;
    int               k;
    row = '0;
    if (mode == 0) begin
      row[col*16 +: 16] = $urandom_range(1) ? 16'h4000 : 16'hc000;
    end else if (mode == 1) begin
      row = {16'($urandom), 32'($urandom)};
    end else begin
      for (k = 0; k < 3; k++)
        row[k*16 +: 16] = 16'(int'($urandom_range(6000)) - 3000 + ((k == col) ? 16384 : 0));
    end
    return row;
  endfunction

  // upper bits carry junk that the 15-bit registers must drop
  function automatic logic [REG_W-1:0] with_junk(int val);
    return {16'($urandom), 17'($urandom), 15'(val)};
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ROT_X:    field_cfg.rot_x = data;
      REG_ROT_Y:    field_cfg.rot_y = data;
      REG_ROT_Z:    field_cfg.rot_z = data;
      REG_CAM_POS:  field_cfg.cam_pos = data;
      REG_MARGIN:   field_cfg.margin = data[LIM_W-1:0];
      REG_HALF_LEN: field_cfg.half_len = data[LIM_W-1:0];
      REG_HALF_WID: field_cfg.half_wid = data[LIM_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ray(ray_t x, ray_t y, ray_t z, bit typed, cause_t cause);
    int       gap;
    verdict_t v;
    gap = 0;
    if (rays_sent < STEADY_FROM || rays_sent >= STEADY_TO)
      while (gap < 20 && $urandom_range(99) < 23) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ray_cam_x <= x;
    in_ray_cam_y <= y;
    in_ray_cam_z <= z;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      v.oof = (cause != CAUSE_ON_CARPET);
      v.cause = cause;
    end else begin
      v = classify_ray(x, y, z);
    end
    expect_verdict(v);
    rays_sent++;
  endtask

  // stop offering, drain the pipeline and let it go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected transaction, out_of_field %0b cause %0d",
                 $time, out_out_of_field, out_cause);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_out_of_field !== want.oof) begin
          $display("%0t: out_of_field mismatch, expected %0b actual %0b",
                   $time, want.oof, out_out_of_field);
          errors++;
        end
        if (out_cause !== want.cause) begin
          $display("%0t: cause mismatch, expected %0d actual %0d",
                   $time, want.cause, out_cause);
          errors++;
        end
        cause_tally[want.cause]++;
      end
      results_seen++;
      if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
        hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int               mode, a, b, c, r, len, wid;
    logic [REG_W-1:0] pos;

    field_cfg.rot_x = ROT_X_RST;
    field_cfg.rot_y = ROT_Y_RST;
    field_cfg.rot_z = ROT_Z_RST;
    field_cfg.cam_pos = '0;
    field_cfg.margin = '0;
    field_cfg.half_len = HALF_LEN_RST;
    field_cfg.half_wid = HALF_WID_RST;

    // reset settings: camera at the origin, so any downward ray is on the carpet
    add_step(ray_step(16'sh0000, 16'sh0000, 16'sh4000, 1'b1, CAUSE_HORIZON));
    add_step(ray_step(16'sh0000, 16'sh0000, -16'sh4000, 1'b1, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, CAUSE_HORIZON));
    add_step(ray_step(16'sh4000, 16'sh4000, -16'sh0001, 1'b1, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, CAUSE_HORIZON));
    add_step(ray_step(-16'sh4000, 16'sh4000, 16'sh0001, 1'b1, CAUSE_HORIZON));
    // camera 1 m up, margin right at the ray's z
    add_step(write_step(REG_CAM_POS, 48'h03e8_0000_0000));
    add_step(write_step(REG_MARGIN, 48'd1000));
    add_step(ray_step(16'sh0000, 16'sh0000, -16'sd1000, 1'b1, CAUSE_HORIZON));
    add_step(ray_step(16'sh0000, 16'sh0000, -16'sd1001, 1'b1, CAUSE_ON_CARPET));
    // carpet edges, exactly on and just past
    add_step(ray_step(16'sd11400, 16'sh0000, -16'sd2000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sd11401, 16'sh0000, -16'sd2000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(-16'sd11401, 16'sh0000, -16'sd2000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh0000, 16'sd7400, -16'sd2000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh0000, -16'sd7401, -16'sd2000, 1'b0, CAUSE_ON_CARPET));
    // bit 15 and above dropped, and a write past the register list ignored
    add_step(write_step(REG_MARGIN, 48'hffff_ffff_8000));
    add_step(write_step(REG_UNUSED, 48'h0));
    add_step(ray_step(16'sh0000, 16'sh0000, -16'sd1000, 1'b0, CAUSE_ON_CARPET));
    // full-scale rotation rows and position parts of both signs, widest length, zero width
    add_step(write_step(REG_ROT_X, 48'h8000_8000_8000));
    add_step(write_step(REG_ROT_Y, 48'h7fff_7fff_7fff));
    add_step(write_step(REG_ROT_Z, 48'h8000_8000_8000));
    add_step(write_step(REG_CAM_POS, 48'h7fff_8000_8000));
    add_step(write_step(REG_HALF_LEN, 48'h7fff));
    add_step(write_step(REG_HALF_WID, 48'h0));
    add_step(ray_step(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh4000, 16'sh0000, 16'sh0000, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh0001, 16'sh0000, 16'sh0000, 1'b0, CAUSE_ON_CARPET));
    add_step(write_step(REG_HALF_LEN, 48'h0));
    add_step(write_step(REG_HALF_WID, 48'h7fff));
    add_step(ray_step(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, CAUSE_ON_CARPET));
    add_step(ray_step(16'sh0001, 16'sh0000, 16'sh0000, 1'b0, CAUSE_ON_CARPET));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_RAY) begin
        send_ray(plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].cause);
      end else begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 1) begin
        write_reg(REG_ROT_X, 48'h8000_8000_8000);
        write_reg(REG_ROT_Y, 48'h8000_8000_8000);
        write_reg(REG_ROT_Z, 48'h8000_8000_8000);
        write_reg(REG_CAM_POS, 48'h8000_8000_8000);
        write_reg(REG_MARGIN, with_junk(0));
        write_reg(REG_HALF_LEN, with_junk(0));
        write_reg(REG_HALF_WID, with_junk(0));
      end else if (phase == 2) begin
        write_reg(REG_ROT_X, 48'h7fff_7fff_7fff);
        write_reg(REG_ROT_Y, 48'h7fff_7fff_7fff);
        write_reg(REG_ROT_Z, 48'h7fff_7fff_7fff);
        write_reg(REG_CAM_POS, 48'h7fff_7fff_7fff);
        write_reg(REG_MARGIN, with_junk(32767));
        write_reg(REG_HALF_LEN, with_junk(32767));
        write_reg(REG_HALF_WID, with_junk(32767));
      end else begin
        mode = $urandom_range(2);
        a = $urandom_range(2);
        b = (a + 1 + $urandom_range(1)) % 3;
        c = 3 - a - b;
        write_reg(REG_ROT_X, make_row(a, mode));
        write_reg(REG_ROT_Y, make_row(b, mode));
        write_reg(REG_ROT_Z, make_row(c, mode));
        if ($urandom_range(4) == 0)
          pos = {16'($urandom), 32'($urandom)};
        else
          pos = {16'($urandom_range(1500, 200)), 16'(int'($urandom_range(8000)) - 4000),
                 16'(int'($urandom_range(8000)) - 4000)};
        write_reg(REG_CAM_POS, pos);
        write_reg(REG_MARGIN, with_junk(($urandom_range(9) == 0) ? $urandom_range(32767)
                                                                 : $urandom_range(3000)));
        r = $urandom_range(9);
        len = (r == 0) ? 0 : (r == 1) ? 32767 : (r == 2) ? $urandom_range(32767)
                                                         : $urandom_range(8000, 2000);
        r = $urandom_range(9);
        wid = (r == 0) ? 0 : (r == 1) ? 32767 : (r == 2) ? $urandom_range(32767)
                                                         : $urandom_range(6000, 1000);
        write_reg(REG_HALF_LEN, with_junk(len));
        write_reg(REG_HALF_WID, with_junk(wid));
      end
      write_reg(REG_UNUSED, {16'($urandom), 32'($urandom)});
      repeat (RAYS_PER_PHASE)
        send_ray(pick_component(), pick_component(), pick_component(), 1'b0, CAUSE_ON_CARPET);
    end

    settle();
    $display("%0d rays over %0d register writes: %0d on carpet, %0d above horizon, %0d beyond",
             rays_sent, cfg_writes, cause_tally[CAUSE_ON_CARPET], cause_tally[CAUSE_HORIZON],
             cause_tally[CAUSE_BEYOND]);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
